// File: src/sesm_pkg.sv
package sesm_pkg;

  localparam int NUM_STREAMS_DEF  = 10;
  localparam int STREAM_DEPTH_DEF = 256;

  localparam int TIME_W   = 32;
  localparam int CODE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int ACT_W    = 4;
  localparam int CAP_W    = 12;
  localparam int CFG_W    = 12;

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(10);
  localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(2560);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ITEM        = 3'd0,
    ST_DONE        = 3'd1,
    ST_DUP         = 3'd2,
    ST_UNSORTED    = 3'd3,
    ST_NOTCONSUMED = 3'd4
  } status_t;

  typedef enum logic {
    CFG_ACTIVE   = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]   out_time;
    logic [CODE_W-1:0]   out_code;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

endpackage

// File: src/sesm_ram.sv
module sesm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sesm_ctrl.sv
module sesm_ctrl #(
  parameter int NUM_STREAMS  = sesm_pkg::NUM_STREAMS_DEF,
  parameter int STREAM_DEPTH = sesm_pkg::STREAM_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [3:0]                  in_stream,
  input  logic [sesm_pkg::TIME_W-1:0] in_time,
  input  logic [sesm_pkg::CODE_W-1:0] in_code,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sesm_pkg::CFG_W-1:0]  cfg_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output sesm_pkg::res_t              res
);

  localparam int SIW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
  localparam int CNW = $clog2(NUM_STREAMS + 1);
  localparam int PW  = $clog2(STREAM_DEPTH + 1);
  localparam int AW  = $clog2(NUM_STREAMS * STREAM_DEPTH);
  localparam int EW  = sesm_pkg::TIME_W + sesm_pkg::CODE_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CAP    = 7'b0000010,
    S_HEAD   = 7'b0000100,
    S_WAIT   = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_SPARE  = 7'b1000000
  } state_t;

  state_t state;
  logic [CNW-1:0] n;
  logic [CNW-1:0] nact;
  logic found;
  logic [SIW-1:0] best_idx;
  logic [sesm_pkg::TIME_W-1:0] best_time;
  logic [sesm_pkg::CODE_W-1:0] best_code;
  logic [PW-1:0] len [NUM_STREAMS];
  logic [PW-1:0] pos [NUM_STREAMS];
  logic [sesm_pkg::CAP_W-1:0] emitted;
  logic [sesm_pkg::TIME_W-1:0] prev_time;
  logic stopped;
  logic [sesm_pkg::ACT_W-1:0] active;
  logic [sesm_pkg::CAP_W-1:0] capacity;

  logic [SIW-1:0] cur;
  logic [SIW-1:0] ld_idx;
  logic ld_ok;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [sesm_pkg::TIME_W-1:0] rd_time;
  logic [sesm_pkg::CODE_W-1:0] rd_code;

  assign cur    = n[SIW-1:0];
  assign ld_idx = SIW'(in_stream);
  assign nact   = ({1'b0, active} > 5'(NUM_STREAMS)) ? CNW'(NUM_STREAMS) : CNW'(active);
  assign ld_ok  = ({1'b0, in_stream} < 5'(NUM_STREAMS)) &&
                  (len[ld_idx] < PW'(STREAM_DEPTH));
  assign in_ready = (state == S_IDLE);
  assign we     = in_valid && in_ready && (in_op == sesm_pkg::OP_LOAD) && ld_ok;
  assign waddr  = AW'(ld_idx) * AW'(STREAM_DEPTH) + AW'(len[ld_idx]);
  assign wdata  = {in_code, in_time};
  assign raddr  = AW'(cur) * AW'(STREAM_DEPTH) + AW'(pos[cur]);
  assign rd_time = rdata[sesm_pkg::TIME_W-1:0];
  assign rd_code = rdata[EW-1:sesm_pkg::TIME_W];
  assign res_valid = (state == S_EMIT);

  sesm_ram #(.WIDTH(EW), .DEPTH(NUM_STREAMS * STREAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      n        <= '0;
      found    <= 1'b0;
      emitted  <= '0;
      prev_time <= '0;
      stopped  <= 1'b0;
      active   <= sesm_pkg::ACTIVE_RESET;
      capacity <= sesm_pkg::CAP_RESET;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        len[i] <= '0;
        pos[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sesm_pkg::CFG_ACTIVE:   active   <= cfg_data[sesm_pkg::ACT_W-1:0];
          sesm_pkg::CFG_CAPACITY: capacity <= cfg_data[sesm_pkg::CAP_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (in_op)
              sesm_pkg::OP_LOAD: begin
                if (ld_ok) begin
                  len[ld_idx] <= len[ld_idx] + 1'b1;
                end
              end
              sesm_pkg::OP_POP: begin
                n     <= '0;
                found <= 1'b0;
                if (!stopped) begin
                  if (nact == '0) begin
                    res     <= '{'0, '0, sesm_pkg::ST_DONE, 1'b1};
                    stopped <= 1'b1;
                    state   <= S_EMIT;
                  end else if (emitted >= capacity) begin
                    state <= S_CAP;
                  end else begin
                    state <= S_HEAD;
                  end
                end
              end
              sesm_pkg::OP_CLEAR: begin
                emitted   <= '0;
                prev_time <= '0;
                stopped   <= 1'b0;
                for (int i = 0; i < NUM_STREAMS; i++) begin
                  len[i] <= '0;
                  pos[i] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_CAP: begin
          if (n == nact) begin
            res     <= '{'0, '0, sesm_pkg::ST_DONE, 1'b1};
            stopped <= 1'b1;
            state   <= S_EMIT;
          end else if (pos[cur] != len[cur]) begin
            res     <= '{'0, '0, sesm_pkg::ST_NOTCONSUMED, 1'b1};
            stopped <= 1'b1;
            state   <= S_EMIT;
          end else begin
            n <= n + 1'b1;
          end
        end
        S_HEAD: begin
          if (n == nact) begin
            state <= S_DECIDE;
          end else if (pos[cur] >= len[cur]) begin
            n <= n + 1'b1;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          state <= S_HEAD;
          if (rd_code == '0) begin
            pos[cur] <= pos[cur] + 1'b1;
          end else if (!found || rd_time < best_time) begin
            found     <= 1'b1;
            best_idx  <= cur;
            best_time <= rd_time;
            best_code <= rd_code;
            n         <= n + 1'b1;
          end else if (rd_time == best_time) begin
            res     <= '{'0, '0, sesm_pkg::ST_DUP, 1'b1};
            stopped <= 1'b1;
            state   <= S_EMIT;
          end else begin
            n <= n + 1'b1;
          end
        end
        S_DECIDE: begin
          state <= S_EMIT;
          if (!found) begin
            res     <= '{'0, '0, sesm_pkg::ST_DONE, 1'b1};
            stopped <= 1'b1;
          end else if (emitted != '0 && best_time < prev_time) begin
            res     <= '{'0, '0, sesm_pkg::ST_UNSORTED, 1'b1};
            stopped <= 1'b1;
          end else begin
            res           <= '{best_time, best_code, sesm_pkg::ST_ITEM, 1'b0};
            pos[best_idx] <= pos[best_idx] + 1'b1;
            emitted       <= emitted + 1'b1;
            prev_time     <= best_time;
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/sorted_event_sequence_merge_top.sv
// Merges up to NUM_STREAMS time-sorted event streams into one sequence.
// Input beats arrive on the s_ channel; s_tuser carries the operation
// (load, pop, clear) and s_tdata the stream, time and code of a load.
// Only a pop produces a beat on the m_ channel: a merged item with its
// status in m_tuser, or, when the merge ends by done or error, time and
// code zero with m_tlast high. After that, pops give nothing until a clear.
// Loads and clears complete without leaving the idle state. A pop walks
// the active stream heads through the entry memory, which has one read
// port with a registered read: an empty stream is passed over, a stream
// with a head has its head read, each code-zero entry is skipped and the
// next entry read, and then the smallest head time is decided. With the
// output capacity reached, the check instead visits each active stream
// for unconsumed entries. The output register lets the next item be
// accepted while a result waits; a stall of m_tready holds the beat and
// stops a following pop from finishing. Reset clears all lengths,
// positions and flags and restores the register defaults; the entry
// memory itself is not cleared.
module sorted_event_sequence_merge_top #(
  parameter int NUM_STREAMS  = sesm_pkg::NUM_STREAMS_DEF,
  parameter int STREAM_DEPTH = sesm_pkg::STREAM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // stream[3:0], event_time[35:4], event_code[43:36], zero
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_time[31:0], out_code[39:32]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  sesm_pkg::res_t res;
  logic res_valid;
  logic res_ready;

  assign res_ready = !m_tvalid || m_tready;

  sesm_ctrl #(.NUM_STREAMS(NUM_STREAMS), .STREAM_DEPTH(STREAM_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_stream (s_tdata[3:0]),
    .in_time   (s_tdata[35:4]),
    .in_code   (s_tdata[43:36]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {res.out_code, res.out_time};
      m_tuser <= res.status;
      m_tlast <= res.last;
    end
  end

endmodule

// File: src/sesm_checker.sv
module sesm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Output beat changed while stalled.");

  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser != sesm_pkg::ST_ITEM)))
    else $error("Last flag does not match status.");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == '0)
    else $error("Final beat carries nonzero data.");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= sesm_pkg::ST_NOTCONSUMED)
    else $error("Status code out of range.");

endmodule

bind sorted_event_sequence_merge_top sesm_checker u_sesm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: tb/sv/testbench.sv
module testbench;
  import sesm_pkg::*;

  localparam int NS = NUM_STREAMS_DEF;
  localparam int DEPTH = STREAM_DEPTH_DEF;
  localparam int SETTLE = 6000;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    op_t         op;
    logic [3:0]  stream;
    logic [31:0] ev_time;
    logic [7:0]  code;
  } beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_data;

  beat_t pending_beats[$];
  res_t  expected_merge[$];

  logic [31:0] time_mem[NS][DEPTH];
  logic [7:0]  code_mem[NS][DEPTH];
  int          length_of[NS];
  int          head_of[NS];
  int          emitted;
  logic [31:0] prev_out_time;
  bit          stopped;
  int          active_cfg;
  int          capacity_cfg;

  int  send_idle;
  int  recv_idle;
  bit  hold_req;
  bit  hold_done;
  int  hold_left;
  int  errors;
  int  cycles;

  sorted_event_sequence_merge_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic clear_merge();
    for (int n = 0; n < NS; n++) begin
      length_of[n] = 0;
      head_of[n] = 0;
    end
    emitted = 0;
    prev_out_time = '0;
    stopped = 1'b0;
  endtask

  task automatic merge_beat(op_t op, logic [3:0] s, logic [31:0] t, logic [7:0] c);
    int nact;
    int best;
    bit found;
    bit ended;
    logic [31:0] best_time;
    logic [31:0] head_time;
    logic [7:0] best_code;
    status_t st;
    res_t r;
    nact = active_cfg > NS ? NS : active_cfg;
    found = 1'b0;
    ended = 1'b0;
    best = 0;
    best_time = '0;
    best_code = '0;
    st = ST_DONE;
    case (op)
      OP_LOAD: begin
        if (s < NS && length_of[s] < DEPTH) begin
          time_mem[s][length_of[s]] = t;
          code_mem[s][length_of[s]] = c;
          length_of[s]++;
        end
      end
      OP_CLEAR: begin
        clear_merge();
      end
      OP_POP: begin
        if (!stopped) begin
          if (nact == 0) begin
            ended = 1'b1;
          end else if (emitted >= capacity_cfg) begin
            ended = 1'b1;
            for (int n = 0; n < nact; n++)
              if (head_of[n] != length_of[n]) st = ST_NOTCONSUMED;
          end else begin
            for (int n = 0; n < nact && !ended; n++) begin
              while (head_of[n] < length_of[n] && code_mem[n][head_of[n]] == 0)
                head_of[n]++;
              if (head_of[n] < length_of[n]) begin
                head_time = time_mem[n][head_of[n]];
                if (!found || head_time < best_time) begin
                  found = 1'b1;
                  best = n;
                  best_time = head_time;
                  best_code = code_mem[n][head_of[n]];
                end else if (head_time == best_time) begin
                  ended = 1'b1;
                  st = ST_DUP;
                end
              end
            end
            if (!ended) begin
              if (!found) begin
                ended = 1'b1;
              end else if (emitted > 0 && best_time < prev_out_time) begin
                ended = 1'b1;
                st = ST_UNSORTED;
              end else begin
                head_of[best]++;
                emitted = (emitted + 1) % 4096;
                prev_out_time = best_time;
                r.out_time = best_time;
                r.out_code = best_code;
                r.status = ST_ITEM;
                r.last = 1'b0;
                expected_merge.push_back(r);
              end
            end
          end
          if (ended) begin
            stopped = 1'b1;
            r.out_time = '0;
            r.out_code = '0;
            r.status = st;
            r.last = 1'b1;
            expected_merge.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_beats.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
        b = pending_beats.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, b.code, b.ev_time, b.stream};
        s_tuser <= b.op;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99, 0) >= recv_idle;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && s_tvalid && s_tready)
      merge_beat(op_t'(s_tuser), s_tdata[3:0], s_tdata[35:4], s_tdata[43:36]);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_merge.size() == 0) begin
        $display("%0t: unexpected beat time=%h code=%h status=%0d last=%b",
                 $time, m_tdata[31:0], m_tdata[39:32], m_tuser, m_tlast);
        errors++;
      end else begin
        want = expected_merge.pop_front();
        if (m_tdata[31:0] !== want.out_time || m_tdata[39:32] !== want.out_code ||
            m_tuser !== want.status || m_tlast !== want.last) begin
          $display("%0t: expected time=%h code=%h status=%0d last=%b", $time,
                   want.out_time, want.out_code, want.status, want.last);
          $display("%0t: actual   time=%h code=%h status=%0d last=%b", $time,
                   m_tdata[31:0], m_tdata[39:32], m_tuser, m_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_beat(op_t op, int s, logic [31:0] t, logic [7:0] c);
    beat_t b;
    b.op = op;
    b.stream = s[3:0];
    b.ev_time = t;
    b.code = c;
    pending_beats.push_back(b);
  endtask

  task automatic add_sorted_run(bit broken);
    int len;
    int total;
    logic [31:0] t;
    logic [7:0] c;
    total = 0;
    add_beat(OP_CLEAR, $urandom_range(15, 0), $urandom, 8'($urandom));
    for (int n = 0; n < NS; n++) begin
      len = $urandom_range(5, 0);
      t = ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(20, 0);
      for (int k = 0; k < len; k++) begin
        c = ($urandom_range(7, 0) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
        if (broken && $urandom_range(3, 0) == 0) t = $urandom;
        add_beat(OP_LOAD, n, t, c);
        t = t + $urandom_range(($urandom_range(1, 0) == 0) ? 3 : 60000, 1);
        total++;
      end
    end
    for (int k = 0; k < total + 2; k++)
      add_beat(OP_POP, $urandom_range(15, 0), $urandom, 8'($urandom));
  endtask

  task automatic add_noise();
    for (int k = 0; k < 5; k++)
      add_beat(op_t'($urandom_range(3, 0)), $urandom_range(15, 0), $urandom,
               8'($urandom));
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[11:0];
    if (idx == CFG_ACTIVE) active_cfg = value % 16;
    else capacity_cfg = value % 4096;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || s_tvalid || expected_merge.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  int act_list[8] = '{10, 1, 15, 0, 3, 10, 7, 10};
  int cap_list[8] = '{2560, 1, 4095, 5, 3, 0, 2560, 20};

  initial begin
    int added;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_ACTIVE;
    cfg_data = '0;
    send_idle = 6;
    recv_idle = 72;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    errors = 0;
    cycles = 0;
    clear_merge();
    active_cfg = 10;
    capacity_cfg = 2560;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_beat(OP_LOAD, 0, 32'd0, 8'd1);
    add_beat(OP_LOAD, 9, 32'hFFFF_FFFF, 8'd255);
    add_beat(OP_LOAD, 3, 32'd7, 8'd0);
    add_beat(OP_LOAD, 3, 32'd9, 8'd2);
    add_beat(OP_LOAD, 12, 32'd4, 8'd3);
    add_beat(OP_NONE, 15, 32'hFFFF_FFFF, 8'hFF);
    repeat (4) add_beat(OP_POP, 0, '0, '0);
    add_beat(OP_LOAD, 1, 32'd3, 8'd4);
    add_beat(OP_POP, 0, '0, '0);
    add_beat(OP_CLEAR, 0, '0, '0);
    add_beat(OP_LOAD, 1, 32'd5, 8'd6);
    add_beat(OP_LOAD, 2, 32'd5, 8'd7);
    add_beat(OP_POP, 0, '0, '0);
    add_beat(OP_CLEAR, 0, '0, '0);
    add_beat(OP_LOAD, 0, 32'd100, 8'd8);
    add_beat(OP_POP, 0, '0, '0);
    add_beat(OP_LOAD, 1, 32'd50, 8'd9);
    add_beat(OP_POP, 0, '0, '0);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_ACTIVE, act_list[p]);
      write_reg(CFG_CAPACITY, cap_list[p]);
      @(posedge clk);
      send_idle <= (p < 3) ? 6 : (p < 6) ? 72 : 0;
      recv_idle <= (p < 3) ? 72 : (p < 6) ? 6 : 0;
      hold_req <= (p == 7);
      if (p == 7) begin
        add_beat(OP_CLEAR, 0, '0, '0);
        for (int k = 0; k < DEPTH + 2; k++)
          add_beat(OP_LOAD, 0, k, 8'($urandom_range(255, 1)));
        repeat (24) add_beat(OP_POP, 0, '0, '0);
      end
      added = 0;
      while (added < 50) begin
        if ($urandom_range(4, 0) == 0) begin
          add_noise();
          added += 5;
        end else begin
          add_sorted_run($urandom_range(9, 0) == 0);
          added += 40;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: sim.f
src/sesm_pkg.sv
src/sesm_ram.sv
src/sesm_ctrl.sv
src/sorted_event_sequence_merge_top.sv
src/sesm_checker.sv
tb/sv/testbench.sv
